// ===== hw/rtl/spf_pkg.sv =====
`default_nettype none
package spf_pkg;
    localparam int MAX_N_DEF = 4096;
    localparam int MAX_DIV_DEF = 64;
    localparam int MAX_RESULTS = 48;
    localparam int VW = 13;
    localparam int EW = 4;
    localparam int SW = 2;

    localparam logic [0:0] REG_LIMIT = 1'd0;
    localparam logic [0:0] REG_MODE = 1'd1;

    localparam logic [SW-1:0] ST_OK = 2'd0;
    localparam logic [SW-1:0] ST_RANGE = 2'd1;
    localparam logic [SW-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CLS_NORMAL,
        CLS_RANGE,
        CLS_SMALL
    } cls_t;

    typedef struct packed {
        logic [VW-1:0] n;
        cls_t cls;
        logic mode;
    } req_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CLR,
        B_SIEVE_RD,
        B_SIEVE_CHK,
        B_MARK_RD,
        B_MARK_CHK,
        B_FETCH,
        B_FWAIT,
        B_FDIV,
        B_PAIR,
        B_DRD,
        B_DWAIT,
        B_DMUL,
        B_EMIT_RD,
        B_EMIT_OUT,
        B_STATUS
    } bstate_t;
endpackage
`default_nettype wire

// ===== hw/rtl/spf_sieve_factor_divisors_top.sv =====
// channel   dir  signals                                   handshake
// request   in   query_value                               start & !busy
// result    out  value, exponent, last, status             valid, one cycle
// config    in   cfg_index, cfg_data                       cfg_we
// First request after reset or limit write runs the sieve: all MAX_N+1 table
// entries are cleared, then candidates and their multiples are read and checked.
// A query looks up each prime factor in the table and divides it out in a
// subtract loop; mode 0 emits prime/exponent pairs, mode 1 builds and emits divisors.
// busy rises when the 2-entry request queue is full. Results cannot be held.
`default_nettype none
module spf_sieve_factor_divisors_top #(
    parameter int MAX_N = spf_pkg::MAX_N_DEF,
    parameter int MAX_DIVISORS = spf_pkg::MAX_DIV_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [spf_pkg::VW-1:0] query_value,
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_index,
    input  wire logic [spf_pkg::VW-1:0] cfg_data,
    output logic                        valid,
    output logic [spf_pkg::VW-1:0]      value,
    output logic [spf_pkg::EW-1:0]      exponent,
    output logic                        last,
    output logic [spf_pkg::SW-1:0]      status
);
    import spf_pkg::*;

    logic [VW-1:0] limit_reg;
    logic mode_reg;
    logic q_valid, deq, rebuild;
    req_t q_data;

    assign rebuild = cfg_we && (cfg_index == REG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= VW'(4096);
            mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
            else
            begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    spf_front #(.MAX_N(MAX_N)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .query_value(query_value),
        .limit_n(limit_reg), .mode(mode_reg), .deq(deq), .busy(busy),
        .q_valid(q_valid), .q_data(q_data)
    );

    spf_back #(.MAX_N(MAX_N), .MAX_DIVISORS(MAX_DIVISORS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .deq(deq),
        .limit_n(limit_reg), .rebuild(rebuild), .valid(valid), .value(value),
        .exponent(exponent), .last(last), .status(status)
    );

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_OK |-> last)
        else $error("status result without last");
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_RANGE |-> value == '0 && exponent == '0)
        else $error("range error carries payload");
    a_deq_valid: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> q_valid)
        else $error("dequeue from empty queue");
endmodule
`default_nettype wire

// ===== hw/rtl/spf_ram.sv =====
`default_nettype none
module spf_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/spf_front.sv =====
`default_nettype none
module spf_front #(
    parameter int MAX_N = spf_pkg::MAX_N_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [spf_pkg::VW-1:0] query_value,
    input  wire logic [spf_pkg::VW-1:0] limit_n,
    input  wire logic                   mode,
    input  wire logic                   deq,
    output logic                        busy,
    output logic                        q_valid,
    output spf_pkg::req_t               q_data
);
    import spf_pkg::*;

    localparam logic [VW:0] MAXN_W = (VW+1)'(MAX_N);

    logic [1:0] cnt_reg, cnt_next;
    req_t       ent_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [VW:0] lim;
    req_t       nr;
    logic       acc;

    assign lim = ({1'b0, limit_n} > MAXN_W) ? MAXN_W : {1'b0, limit_n};
    assign busy = (cnt_reg == 2'd2);
    assign acc = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = ent_reg[rd_reg];

    always_comb
    begin
        nr.n = query_value;
        nr.mode = mode;
        if ({1'b0, query_value} > lim)
        begin
            nr.cls = CLS_RANGE;
        end
        else if (query_value < VW'(2))
        begin
            nr.cls = CLS_SMALL;
        end
        else
        begin
            nr.cls = CLS_NORMAL;
        end
        cnt_next = cnt_reg + 2'(acc) - 2'(deq && q_valid);
        rd_next = rd_reg ^ (deq && q_valid);
        wr_next = wr_reg ^ acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ent_reg[wr_reg] <= nr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/spf_back.sv =====
`default_nettype none
module spf_back #(
    parameter int MAX_N = spf_pkg::MAX_N_DEF,
    parameter int MAX_DIVISORS = spf_pkg::MAX_DIV_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire spf_pkg::req_t          q_data,
    output logic                        deq,
    input  wire logic [spf_pkg::VW-1:0] limit_n,
    input  wire logic                   rebuild,
    output logic                        valid,
    output logic [spf_pkg::VW-1:0]      value,
    output logic [spf_pkg::EW-1:0]      exponent,
    output logic                        last,
    output logic [spf_pkg::SW-1:0]      status
);
    import spf_pkg::*;

    localparam int TD = MAX_N + 1;
    localparam int TA = $clog2(TD);
    localparam int DA = $clog2(MAX_DIVISORS);
    localparam int CW = DA + 1;
    localparam logic [TA:0] MAXN_W = (TA+1)'(MAX_N);
    localparam logic [CW-1:0] MAXD_C = CW'(MAX_DIVISORS);
    localparam logic [CW-1:0] MAXR_C = CW'(MAX_RESULTS);

    bstate_t state_reg, state_next;
    logic built_reg, built_next;
    logic [TA:0] p_reg, p_next, q_reg, q_next;
    logic [VW-1:0] n_reg, n_next, cp_reg, cp_next;
    logic [EW-1:0] e_reg, e_next;
    logic [VW-1:0] quo_reg, quo_next;
    logic mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next, s_reg, s_next, idx_reg, idx_next;
    logic [EW-1:0] j_reg, j_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] val_reg, val_next;
    logic [EW-1:0] exp_reg, exp_next;
    logic last_reg, last_next, vld_reg, vld_next;
    logic [SW-1:0] st_reg, st_next;
    logic [CW-1:0] tot_reg, tot_next;

    logic t_we;
    logic [TA-1:0] t_wa, t_ra;
    logic [VW-1:0] t_wd, t_rd;
    logic d_we;
    logic [DA-1:0] d_wa, d_ra;
    logic [VW-1:0] d_wd, d_rd;
    logic [TA:0] lim;
    logic [2*VW-1:0] prod;

    spf_ram #(.WIDTH(VW), .DEPTH(TD)) u_tab (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
    );
    spf_ram #(.WIDTH(VW), .DEPTH(MAX_DIVISORS)) u_div (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
    );

    assign lim = ({1'b0, limit_n} > (VW+1)'(MAXN_W)) ? MAXN_W : (TA+1)'(limit_n);
    assign prod = d_rd * v_reg;
    assign valid = vld_reg;
    assign value = val_reg;
    assign exponent = exp_reg;
    assign last = last_reg;
    assign status = st_reg;

    always_comb
    begin
        state_next = state_reg;
        built_next = built_reg && !rebuild;
        p_next = p_reg;
        q_next = q_reg;
        n_next = n_reg;
        cp_next = cp_reg;
        e_next = e_reg;
        quo_next = quo_reg;
        mode_next = mode_reg;
        cnt_next = cnt_reg;
        s_next = s_reg;
        idx_next = idx_reg;
        j_next = j_reg;
        v_next = v_reg;
        tot_next = tot_reg;
        val_next = val_reg;
        exp_next = '0;
        last_next = 1'b0;
        vld_next = 1'b0;
        st_next = ST_OK;
        deq = 1'b0;
        t_we = 1'b0;
        t_wa = TA'(q_reg);
        t_wd = '0;
        t_ra = TA'(q_reg);
        d_we = 1'b0;
        d_wa = DA'(cnt_reg);
        d_wd = '0;
        d_ra = DA'(idx_reg);
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (!built_reg)
                    begin
                        q_next = '0;
                        state_next = B_CLR;
                    end
                    else
                    begin
                        deq = 1'b1;
                        n_next = q_data.n;
                        mode_next = q_data.mode;
                        cnt_next = CW'(1);
                        if (q_data.cls == CLS_RANGE)
                        begin
                            val_next = '0;
                            st_next = ST_RANGE;
                            state_next = B_STATUS;
                        end
                        else if (q_data.cls == CLS_SMALL)
                        begin
                            val_next = q_data.mode ? VW'(1) : '0;
                            st_next = q_data.mode ? ST_OK : ST_EMPTY;
                            state_next = B_STATUS;
                        end
                        else
                        begin
                            // divisor list starts with 1
                            d_we = 1'b1;
                            d_wa = '0;
                            d_wd = VW'(1);
                            cp_next = '0;
                            e_next = '0;
                            state_next = B_FETCH;
                        end
                    end
                end
            end
            B_CLR:
            begin
                t_we = 1'b1;
                t_wd = (q_reg == (TA+1)'(1)) ? VW'(1) : '0;
                q_next = q_reg + 1'b1;
                if (q_reg == MAXN_W)
                begin
                    p_next = (TA+1)'(2);
                    state_next = B_SIEVE_RD;
                end
            end
            B_SIEVE_RD:
            begin
                t_ra = TA'(p_reg);
                if (p_reg > lim)
                begin
                    built_next = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    state_next = B_SIEVE_CHK;
                end
            end
            B_SIEVE_CHK:
            begin
                if (t_rd != '0)
                begin
                    p_next = p_reg + 1'b1;
                    state_next = B_SIEVE_RD;
                end
                else
                begin
                    t_we = 1'b1;
                    t_wa = TA'(p_reg);
                    t_wd = VW'(p_reg);
                    q_next = p_reg + p_reg;
                    state_next = B_MARK_RD;
                end
            end
            B_MARK_RD:
            begin
                t_ra = TA'(q_reg);
                if (q_reg > lim)
                begin
                    p_next = p_reg + 1'b1;
                    state_next = B_SIEVE_RD;
                end
                else
                begin
                    state_next = B_MARK_CHK;
                end
            end
            B_MARK_CHK:
            begin
                if (t_rd == '0)
                begin
                    t_we = 1'b1;
                    t_wa = TA'(q_reg);
                    t_wd = VW'(p_reg);
                end
                q_next = q_reg + p_reg;
                state_next = B_MARK_RD;
            end
            B_FETCH:
            begin
                t_ra = TA'(n_reg);
                state_next = B_FWAIT;
            end
            B_FWAIT:
            begin
                t_ra = TA'(n_reg);
                if (n_reg <= VW'(1) || (cp_reg != '0 && t_rd != cp_reg))
                begin
                    state_next = B_PAIR;
                end
                else
                begin
                    cp_next = t_rd;
                    quo_next = '0;
                    state_next = B_FDIV;
                end
            end
            B_FDIV:
            begin
                // repeated subtraction: n / p one step per cycle
                if (n_reg >= cp_reg)
                begin
                    n_next = n_reg - cp_reg;
                    quo_next = quo_reg + 1'b1;
                end
                else
                begin
                    n_next = quo_reg;
                    e_next = e_reg + 1'b1;
                    state_next = B_FETCH;
                    cp_next = cp_reg;
                end
            end
            B_PAIR:
            begin
                if (!mode_reg)
                begin
                    vld_next = 1'b1;
                    val_next = cp_reg;
                    exp_next = e_reg;
                    last_next = (n_reg <= VW'(1));
                    cp_next = '0;
                    e_next = '0;
                    state_next = (n_reg <= VW'(1)) ? B_IDLE : B_FETCH;
                end
                else
                begin
                    s_next = cnt_reg;
                    idx_next = '0;
                    state_next = B_DRD;
                end
            end
            B_DRD:
            begin
                if (idx_reg == s_reg)
                begin
                    if (n_reg <= VW'(1))
                    begin
                        idx_next = '0;
                        tot_next = (cnt_reg > MAXR_C) ? MAXR_C : cnt_reg;
                        state_next = B_EMIT_RD;
                    end
                    else
                    begin
                        cp_next = '0;
                        e_next = '0;
                        state_next = B_FETCH;
                    end
                end
                else
                begin
                    j_next = '0;
                    v_next = VW'(1);
                    state_next = B_DWAIT;
                end
            end
            B_DWAIT:
            begin
                v_next = VW'(v_reg * cp_reg);
                j_next = j_reg + 1'b1;
                state_next = B_DMUL;
            end
            B_DMUL:
            begin
                if (cnt_reg < MAXD_C)
                begin
                    d_we = 1'b1;
                    d_wd = prod[VW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (j_reg == e_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = B_DRD;
                end
                else
                begin
                    state_next = B_DWAIT;
                end
            end
            B_EMIT_RD:
            begin
                state_next = B_EMIT_OUT;
            end
            B_EMIT_OUT:
            begin
                vld_next = 1'b1;
                val_next = (idx_reg == '0) ? VW'(1) : d_rd;
                last_next = (idx_reg + 1'b1 == tot_reg);
                idx_next = idx_reg + 1'b1;
                d_ra = DA'(idx_reg + 1'b1);
                state_next = (idx_reg + 1'b1 == tot_reg) ? B_IDLE : B_EMIT_RD;
            end
            B_STATUS:
            begin
                vld_next = 1'b1;
                last_next = 1'b1;
                st_next = st_reg;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (state_reg == B_IDLE && q_valid && built_reg)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        n_reg <= n_next;
        cp_reg <= cp_next;
        e_reg <= e_next;
        quo_reg <= quo_next;
        mode_reg <= mode_next;
        cnt_reg <= cnt_next;
        s_reg <= s_next;
        idx_reg <= idx_next;
        j_reg <= j_next;
        v_reg <= v_next;
        tot_reg <= tot_next;
        val_reg <= val_next;
        exp_reg <= exp_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            built_reg <= 1'b0;
            vld_reg <= 1'b0;
            st_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            vld_reg <= vld_next;
            st_reg <= st_next;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/spf_sieve_factor_divisors_top_tb.sv =====
`default_nettype none
module spf_sieve_factor_divisors_top_tb;
    import spf_pkg::*;

    typedef struct {
        logic [VW-1:0] value;
        logic [EW-1:0] exponent;
        logic          last;
        logic [SW-1:0] status;
    } factor_item_t;

    typedef struct {
        int            lim;
        int            mode;
        int            n;
        bit            typed;
        logic [VW-1:0] value;
        logic [EW-1:0] exponent;
        logic          last;
        logic [SW-1:0] status;
    } query_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [VW-1:0]       query_value;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [VW-1:0]       cfg_data;
    logic                valid;
    logic [VW-1:0]       value;
    logic [EW-1:0]       exponent;
    logic                last;
    logic [SW-1:0]       status;

    factor_item_t        pending_items[$];
    int                  spf_tab[0:MAX_N_DEF];
    int                  cur_limit;
    int                  cur_mode;
    int                  error_count;
    int                  burst_left;

    spf_sieve_factor_divisors_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .query_value(query_value),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .valid(valid),
        .value(value),
        .exponent(exponent),
        .last(last),
        .status(status)
    );

    always #5 clk = ~clk;

    function automatic int eff_limit();
        return (cur_limit > MAX_N_DEF) ? MAX_N_DEF : cur_limit;
    endfunction

    function automatic void build_sieve();
        int lim;
        lim = eff_limit();
        for (int i = 0; i <= MAX_N_DEF; i++)
            spf_tab[i] = 0;
        spf_tab[1] = 1;
        for (int p = 2; p <= lim; p++) begin
            if (spf_tab[p] == 0) begin
                spf_tab[p] = p;
                for (int q = 2 * p; q <= lim; q += p)
                    if (spf_tab[q] == 0)
                        spf_tab[q] = p;
            end
        end
    endfunction

    function automatic void push_item(int v, int e, bit l, logic [SW-1:0] st);
        factor_item_t it;
        it.value = v[VW-1:0];
        it.exponent = e[EW-1:0];
        it.last = l;
        it.status = st;
        pending_items = {pending_items, it};
    endfunction

    function automatic void predict_factors(int n);
        int primes[16];
        int exps[16];
        int divs[MAX_DIV_DEF];
        int np;
        int nd;
        int m;
        int p;
        int e;
        int s;
        int v;
        int cnt;
        if (n > eff_limit()) begin
            push_item(0, 0, 1, ST_RANGE);
            return;
        end
        np = 0;
        m = n;
        while (m > 1 && np < 16) begin
            p = spf_tab[m];
            e = 0;
            while (m > 1 && spf_tab[m] == p) begin
                m = m / p;
                e++;
            end
            primes[np] = p;
            exps[np] = e;
            np++;
        end
        if (cur_mode == 0) begin
            if (np == 0)
                push_item(0, 0, 1, ST_EMPTY);
            for (int k = 0; k < np; k++)
                push_item(primes[k], exps[k], k == np - 1, ST_OK);
            return;
        end
        divs[0] = 1;
        nd = 1;
        for (int k = 0; k < np; k++) begin
            s = nd;
            for (int idx = 0; idx < s; idx++) begin
                v = 1;
                for (int j = 0; j < exps[k]; j++) begin
                    v = v * primes[k];
                    if (nd < MAX_DIV_DEF) begin
                        divs[nd] = (divs[idx] * v) & 13'h1FFF;
                        nd++;
                    end
                end
            end
        end
        cnt = (nd > MAX_RESULTS) ? MAX_RESULTS : nd;
        for (int i = 0; i < cnt; i++)
            push_item(divs[i], 0, i == cnt - 1, ST_OK);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk) begin
        factor_item_t want;
        if (rst_n && valid) begin
            if (pending_items.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d", value));
            end else begin
                want = pending_items.pop_front();
                if (value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d", value, want.value));
                if (exponent !== want.exponent)
                    report_mismatch($sformatf("exponent %0d, want %0d",
                        exponent, want.exponent));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                        status, want.status));
            end
        end
    end

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [VW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int lim, int mode, bit force_write);
        if (force_write || lim != cur_limit || mode != cur_mode)
            drain();
        if (force_write || lim != cur_limit) begin
            write_reg(REG_LIMIT, lim[VW-1:0]);
            cur_limit = lim;
            build_sieve();
        end
        if (force_write || mode != cur_mode) begin
            write_reg(REG_MODE, {12'($urandom_range(0, 4095)), mode[0]});
            cur_mode = mode;
        end
    endtask

    // one request; start stays high if the next request follows directly
    task automatic send_query(int n, bit typed, factor_item_t typed_item);
        start <= 1'b1;
        query_value <= n[VW-1:0];
        do
            @(posedge clk);
        while (busy);
        if (typed)
            pending_items = {pending_items, typed_item};
        else
            predict_factors(n);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 30)) @(posedge clk);
            else
                @(posedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    query_row_t rows[$];

    function automatic void add_row(int lim, int mode, int n, bit typed = 0,
                                    int v = 0, int e = 0, bit l = 0, int st = 0);
        query_row_t r;
        r.lim = lim;
        r.mode = mode;
        r.n = n;
        r.typed = typed;
        r.value = v[VW-1:0];
        r.exponent = e[EW-1:0];
        r.last = l;
        r.status = st[SW-1:0];
        rows = {rows, r};
    endfunction

    initial begin
        factor_item_t fi;
        int lim;
        int mode;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        query_value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LIMIT;
        cfg_data = '0;
        error_count = 0;
        burst_left = 0;
        cur_limit = 4096;
        cur_mode = 1;
        build_sieve();

        add_row(4096, 1, 0, 1, 1, 0, 1, ST_OK);
        add_row(4096, 1, 1, 1, 1, 0, 1, ST_OK);
        add_row(4096, 1, 4096);
        add_row(4096, 1, 2520);
        add_row(4096, 1, 3360);
        add_row(4096, 1, 4093);
        add_row(4096, 1, 4097, 1, 0, 0, 1, ST_RANGE);
        add_row(4096, 1, 8191, 1, 0, 0, 1, ST_RANGE);
        add_row(4096, 0, 0, 1, 0, 0, 1, ST_EMPTY);
        add_row(4096, 0, 1, 1, 0, 0, 1, ST_EMPTY);
        add_row(4096, 0, 4096, 1, 2, 12, 1, ST_OK);
        add_row(4096, 0, 2310);
        add_row(4096, 0, 4095);
        add_row(4096, 0, 4093, 1, 4093, 1, 1, ST_OK);
        add_row(4096, 0, 6000, 1, 0, 0, 1, ST_RANGE);
        add_row(2, 1, 2);
        add_row(2, 1, 3, 1, 0, 0, 1, ST_RANGE);
        add_row(2, 0, 2, 1, 2, 1, 1, ST_OK);
        add_row(2, 0, 1, 1, 0, 0, 1, ST_EMPTY);
        add_row(8191, 0, 4096, 1, 2, 12, 1, ST_OK);
        add_row(8191, 0, 4097, 1, 0, 0, 1, ST_RANGE);
        add_row(8191, 1, 8191, 1, 0, 0, 1, ST_RANGE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            set_config(rows[i].lim, rows[i].mode, 0);
            fi.value = rows[i].value;
            fi.exponent = rows[i].exponent;
            fi.last = rows[i].last;
            fi.status = rows[i].status;
            send_query(rows[i].n, rows[i].typed, fi);
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: lim = 4096;
                1: lim = $urandom_range(2, 4096);
                2: lim = $urandom_range(2, 64);
                default: lim = 2;
            endcase
            mode = (ph < 2) ? ph : $urandom_range(0, 1);
            set_config(lim, mode, 1);
            for (int k = 0; k < 31; k++) begin
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(0, 8191);
                    1: n = $urandom_range(0, 1);
                    2: n = eff_limit() + $urandom_range(0, 1);
                    default: n = $urandom_range(0, eff_limit());
                endcase
                send_query(n, 0, fi);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("[spf_sieve_factor_divisors_top] OK");
        else
            $display("[spf_sieve_factor_divisors_top] ERROR");
        $finish;
    end

    initial begin
        #60000000;
        $display("[spf_sieve_factor_divisors_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/spf_pkg.sv
hw/rtl/spf_ram.sv
hw/rtl/spf_front.sv
hw/rtl/spf_back.sv
hw/rtl/spf_sieve_factor_divisors_top.sv
tb/sv/spf_sieve_factor_divisors_top_tb.sv
